// File: sv/bluc_pkg.sv
package bluc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned CpW    = 21;

  localparam logic AddrDirection = 1'b0;

  localparam logic [7:0] Unmapped = 8'h3F;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] data0;
    logic       last0;
    logic [7:0] data1;
    logic       last1;
  } res_t;

  function automatic logic is_identity(input logic [7:0] b);
    return (b >= 8'd33 && b <= 8'd126) || (b >= 8'd161 && b <= 8'd172) ||
           (b >= 8'd174);
  endfunction

  function automatic logic [8:0] byte_to_cp(input logic [7:0] b);
    logic [8:0] cp;
    if (is_identity(b)) begin
      cp = {1'b0, b};
    end else if (b < 8'd33) begin
      cp = {1'b1, b};
    end else if (b <= 8'd160) begin
      cp = {1'b1, b - 8'd94};
    end else begin
      cp = {1'b1, 8'd67};
    end
    return cp;
  endfunction

  function automatic logic [7:0] cp_to_byte(input logic [CpW-1:0] cp);
    logic [7:0] r;
    logic [7:0] b;
    r = cp[7:0];
    if (cp[CpW-1:8] == '0) begin
      b = is_identity(r) ? r : Unmapped;
    end else if (cp[CpW-1:9] != '0) begin
      b = Unmapped;
    end else if (r < 8'd33) begin
      b = r;
    end else if (r < 8'd67) begin
      b = r + 8'd94;
    end else if (r == 8'd67) begin
      b = 8'd173;
    end else begin
      b = Unmapped;
    end
    return b;
  endfunction

endpackage

// File: sv/bluc_xlate.sv
module bluc_xlate (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          dir_i,
  input  logic          clr_i,
  input  logic          acc_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output bluc_pkg::res_t res_o
);
  import bluc_pkg::*;

  logic [CpW-1:0] cp_q, cp_d, cp_n;
  logic [1:0]     rem_q, rem_d, rem_n;
  logic           emit;
  logic [8:0]     enc_cp;

  always_comb begin
    rem_n = 2'd0;
    cp_n  = cp_q;
    if (rem_q != 2'd0) begin
      rem_n = rem_q - 2'd1;
      unique case (rem_n)
        2'd0:    cp_n = cp_q | {15'd0, in_byte_i[5:0]};
        2'd1:    cp_n = cp_q | {9'd0, in_byte_i[5:0], 6'd0};
        2'd2:    cp_n = cp_q | {3'd0, in_byte_i[5:0], 12'd0};
        default: cp_n = cp_q;
      endcase
    end else begin
      priority if (in_byte_i[7] == 1'b0) begin
        cp_n = {13'd0, in_byte_i};
      end else if (in_byte_i[7:5] == 3'b110) begin
        cp_n  = {10'd0, in_byte_i[4:0], 6'd0};
        rem_n = 2'd1;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        cp_n  = {5'd0, in_byte_i[3:0], 12'd0};
        rem_n = 2'd2;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        cp_n  = {in_byte_i[2:0], 18'd0};
        rem_n = 2'd3;
      end else begin
        cp_n = {13'd0, in_byte_i};
      end
    end
  end

  assign emit   = (rem_n == 2'd0) || in_last_i;
  assign enc_cp = byte_to_cp(in_byte_i);

  always_comb begin
    res_o = '0;
    if (!dir_i) begin
      if (enc_cp[8:7] == 2'b00) begin
        res_o.cnt   = 2'd1;
        res_o.data0 = enc_cp[7:0];
        res_o.last0 = in_last_i;
      end else begin
        res_o.cnt   = 2'd2;
        res_o.data0 = {5'b11000, enc_cp[8:6]};
        res_o.last0 = 1'b0;
        res_o.data1 = {2'b10, enc_cp[5:0]};
        res_o.last1 = in_last_i;
      end
    end else begin
      res_o.cnt   = emit ? 2'd1 : 2'd0;
      res_o.data0 = cp_to_byte(cp_n);
      res_o.last0 = in_last_i;
    end
  end

  always_comb begin
    cp_d  = cp_q;
    rem_d = rem_q;
    if (clr_i) begin
      cp_d  = '0;
      rem_d = 2'd0;
    end else if (acc_i && dir_i) begin
      cp_d  = emit ? '0 : cp_n;
      rem_d = emit ? 2'd0 : rem_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q  <= '0;
      rem_q <= 2'd0;
    end else begin
      cp_q  <= cp_d;
      rem_q <= rem_d;
    end
  end

  a_state_only_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 2'd0) |-> dir_i)
    else $error("decoder state held in encode mode");

  a_clr_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> (rem_q == 2'd0 && cp_q == '0))
    else $error("decoder state not cleared");

endmodule

// File: sv/byte_level_unicode_codec.sv
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid_i/in_stall_o   | in_byte_i, in_last_i
// out     | output    | out_valid_o/out_stall_i | out_byte_o, out_last_o
// cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
// One request is translated in the cycle it is accepted; its result bytes
// (zero, one or two) land in a three-entry result queue and appear from the
// next cycle. The queue drains one byte a cycle while out_stall_i is low:
// encode of a byte that needs two UTF-8 bytes queues two, any other request
// at most one. in_stall_o rises when two or more result bytes are queued.
// Reset clears the direction (encode), the decoder state and the queue.
module byte_level_unicode_codec (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       in_last_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       out_last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bluc_pkg::AddrW-1:0] paddr,
  input  logic [bluc_pkg::DataW-1:0] pwdata,
  output logic [bluc_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import bluc_pkg::*;

  logic       dir_q;
  logic       cfg_wr;
  logic       in_acc;
  logic       pop;
  res_t       res;
  logic [1:0] cnt_q, cnt_d, cnt_after;
  logic [7:0] data_q [3];
  logic [7:0] data_d [3];
  logic       last_q [3];
  logic       last_d [3];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == AddrDirection);
  assign prdata = (paddr[2] == AddrDirection) ? {{(DataW-1){1'b0}}, dir_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_wr) begin
      dir_q <= pwdata[0];
    end
  end

  assign in_stall_o = cnt_q[1];
  assign in_acc     = in_valid_i && !in_stall_o;

  bluc_xlate u_xlate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .dir_i     (dir_q),
    .clr_i     (cfg_wr),
    .acc_i     (in_acc),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .res_o     (res)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_byte_o  = data_q[0];
  assign out_last_o  = last_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign cnt_after   = cnt_q - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pop && i < 2) begin
        data_d[i] = data_q[(i == 2) ? 2 : i + 1];
        last_d[i] = last_q[(i == 2) ? 2 : i + 1];
      end else begin
        data_d[i] = data_q[i];
        last_d[i] = last_q[i];
      end
      if (in_acc && res.cnt != 2'd0 && cnt_after == 2'(i)) begin
        data_d[i] = res.data0;
        last_d[i] = res.last0;
      end
      if (in_acc && res.cnt == 2'd2 && (cnt_after + 2'd1) == 2'(i)) begin
        data_d[i] = res.data1;
        last_d[i] = res.last1;
      end
    end
    cnt_d = cnt_after + (in_acc ? res.cnt : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (({1'b0, cnt_after} + {1'b0, res.cnt}) <= 3'd3))
    else $error("result queue overflow");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !in_acc) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("result queue lost or gained an entry");

  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (!dir_q || in_last_i)) |=> out_valid_o)
    else $error("expected result missing");

endmodule
